// ----- rtl/core/tebm_pkg.sv -----
// Shared types, codes and defaults for the tiered extent block mapper.
package tebm_pkg;

   localparam int MAX_SLOTS_DEF = 16;
   localparam int BLK_W         = 32;
   localparam int CSR_IDX_W     = 3;
   localparam int TIER_W        = 2;

   typedef enum logic [1:0] {
      STAT_MAPPED  = 2'd0,
      STAT_NEW     = 2'd1,
      STAT_HOLE    = 2'd2,
      STAT_NOSPACE = 2'd3
   } status_type;

   typedef enum logic [TIER_W-1:0] {
      TIER_CODE_NORMAL = 2'd0,
      TIER_CODE_FAST   = 2'd1,
      TIER_CODE_SLOW   = 2'd2,
      TIER_SPARE       = 2'd3
   } tier_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILE_TIER    = 3'd0,
      CSR_FAST_START   = 3'd1,
      CSR_SLOW_START   = 3'd2,
      CSR_NORMAL_START = 3'd3,
      CSR_FREE_START   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      MS_IDLE,
      MS_SEARCH,
      MS_DECIDE
   } map_state_type;

   typedef struct packed {
      logic [BLK_W-1:0] logical_block;
      logic             create;
   } req_data_type;

   typedef struct packed {
      status_type       status;
      logic [BLK_W-1:0] physical_block;
   } rsp_data_type;

   // Lookup transaction travelling along the slot chain
   typedef struct packed {
      logic             valid;
      logic [BLK_W-1:0] logical_block;
      logic             hit;
      logic [BLK_W-1:0] physical_block;
   } chain_pkt_type;

   // Extent written into one slot on allocation
   typedef struct packed {
      logic [BLK_W-1:0] logical_block;
      logic [BLK_W-1:0] physical_block;
   } slot_wr_type;

endpackage

// ----- rtl/core/tebm_cell.sv -----
// One extent slot: holds its mapping and checks the passing lookup against it.
module tebm_cell import tebm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  chain_pkt_type pkt_i,
   output chain_pkt_type pkt_o,
   input  logic          wr_en,
   input  slot_wr_type   wr_data
);

   logic             used_ff;
   logic [BLK_W-1:0] logical_ff;
   logic [BLK_W-1:0] physical_ff;
   chain_pkt_type    pkt_ff;
   chain_pkt_type    pkt_in;

   always_comb begin
      pkt_in = pkt_i;
      // an earlier slot hit already wins, so only claim an unclaimed lookup
      if (pkt_i.valid && !pkt_i.hit && used_ff && (logical_ff == pkt_i.logical_block)) begin
         pkt_in.hit            = 1'b1;
         pkt_in.physical_block = physical_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= 1'b0;
         pkt_ff.valid <= 1'b0;
      end else begin
         pkt_ff.valid <= pkt_in.valid;
         if (wr_en) begin
            used_ff <= 1'b1;
         end
      end
      pkt_ff.logical_block  <= pkt_in.logical_block;
      pkt_ff.hit            <= pkt_in.hit;
      pkt_ff.physical_block <= pkt_in.physical_block;
      if (wr_en) begin
         logical_ff  <= wr_data.logical_block;
         physical_ff <= wr_data.physical_block;
      end
   end

   assign pkt_o = pkt_ff;

endmodule

// ----- rtl/core/tebm_ctrl.sv -----
// Sequencer: launches lookups, allocates blocks from the tier cursors, drives results.
module tebm_ctrl import tebm_pkg::*; #(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_data_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_data_type         rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BLK_W-1:0]     csr_wdata,
   output chain_pkt_type        head_pkt,
   input  chain_pkt_type        tail_pkt,
   output logic [MAX_SLOTS-1:0] slot_wr_en,
   output slot_wr_type          slot_wr
);

   localparam int SLOT_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int FILL_W = $clog2(MAX_SLOTS + 1);

   map_state_type       state_ff, state_in;
   chain_pkt_type       hold_ff, hold_in;
   logic                create_ff, create_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_data_type        rsp_data_ff, rsp_data_in;
   logic [TIER_W-1:0]   tier_ff, tier_in;
   logic [BLK_W-1:0]    fast_ff, fast_in;
   logic [BLK_W-1:0]    slow_ff, slow_in;
   logic [BLK_W-1:0]    normal_ff, normal_in;
   logic [BLK_W-1:0]    free_ff, free_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [BLK_W-1:0]    blk;
   logic [BLK_W-1:0]    blk_next;

   always_comb begin
      priority if (tier_ff == TIER_CODE_FAST) begin
         blk = fast_ff;
      end else if (tier_ff == TIER_CODE_SLOW) begin
         blk = slow_ff;
      end else begin
         blk = normal_ff;
      end
   end

   assign blk_next = blk + {{(BLK_W-1){1'b0}}, 1'b1};

   always_comb begin
      state_in     = state_ff;
      hold_in      = hold_ff;
      create_in    = create_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      tier_in      = tier_ff;
      fast_in      = fast_ff;
      slow_in      = slow_ff;
      normal_in    = normal_ff;
      free_in      = free_ff;
      fill_in      = fill_ff;
      slot_wr_en   = '0;
      slot_wr.logical_block  = hold_ff.logical_block;
      slot_wr.physical_block = blk;
      head_pkt.valid          = req_valid && (state_ff == MS_IDLE);
      head_pkt.logical_block  = req_data.logical_block;
      head_pkt.hit            = 1'b0;
      head_pkt.physical_block = '0;

      unique case (state_ff)
         MS_IDLE: begin
            if (req_valid) begin
               create_in = req_data.create;
               state_in  = MS_SEARCH;
            end
         end
         MS_SEARCH: begin
            if (tail_pkt.valid) begin
               hold_in  = tail_pkt;
               state_in = MS_DECIDE;
            end
         end
         MS_DECIDE: begin
            // wait until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = MS_IDLE;
               priority if (hold_ff.hit) begin
                  rsp_data_in.status         = STAT_MAPPED;
                  rsp_data_in.physical_block = hold_ff.physical_block;
               end else if (!create_ff) begin
                  rsp_data_in.status         = STAT_HOLE;
                  rsp_data_in.physical_block = '0;
               end else if (free_ff == '0) begin
                  rsp_data_in.status         = STAT_NOSPACE;
                  rsp_data_in.physical_block = '0;
               end else begin
                  free_in = free_ff - {{(BLK_W-1){1'b0}}, 1'b1};
                  priority if (tier_ff == TIER_CODE_FAST) begin
                     fast_in = blk_next;
                  end else if (tier_ff == TIER_CODE_SLOW) begin
                     slow_in = blk_next;
                  end else begin
                     normal_in = blk_next;
                  end
                  if (blk == '0) begin
                     rsp_data_in.status         = STAT_NOSPACE;
                     rsp_data_in.physical_block = '0;
                  end else begin
                     rsp_data_in.status         = STAT_NEW;
                     rsp_data_in.physical_block = blk;
                     // slots fill in order, so the fill count names the lowest free slot
                     if (fill_ff != FILL_W'(MAX_SLOTS)) begin
                        slot_wr_en[fill_ff[SLOT_W-1:0]] = 1'b1;
                        fill_in = fill_ff + {{(FILL_W-1){1'b0}}, 1'b1};
                     end
                  end
               end
            end
         end
         default: begin
            state_in = MS_IDLE;
         end
      endcase

      if (csr_we) begin
         unique case (csr_index)
            CSR_FILE_TIER:    tier_in   = csr_wdata[TIER_W-1:0];
            CSR_FAST_START:   fast_in   = csr_wdata;
            CSR_SLOW_START:   slow_in   = csr_wdata;
            CSR_NORMAL_START: normal_in = csr_wdata;
            CSR_FREE_START:   free_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= MS_IDLE;
         rsp_valid_ff <= 1'b0;
         tier_ff      <= TIER_CODE_NORMAL;
         fast_ff      <= '0;
         slow_ff      <= '0;
         normal_ff    <= '0;
         free_ff      <= '0;
         fill_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tier_ff      <= tier_in;
         fast_ff      <= fast_in;
         slow_ff      <= slow_in;
         normal_ff    <= normal_in;
         free_ff      <= free_in;
         fill_ff      <= fill_in;
      end
      hold_ff     <= hold_in;
      create_ff   <= create_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == MS_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- rtl/core/tiered_extent_block_mapper.sv -----
// Tiered extent block mapper: top level joining the sequencer and the slot chain.
//
// Maps a file's logical block to a physical block through MAX_SLOTS one-block
// extents. Requests arrive on req_valid/req_ready/req_data (logical block and
// create flag); one result per request leaves on rsp_valid/rsp_ready/rsp_data
// (status and physical block). Configuration is written through csr_we,
// csr_index and csr_wdata: tier select, the three tier cursors and the free
// counter; write it only while no transaction is in flight.
// Each lookup walks the slot chain one cell per cycle, starting at the
// accepting edge; the hold register captures the chain output behind the last
// cell and allocation is resolved from it in the decide state, which waits for
// the output register to be free. One transaction is in flight at a time.
// The result sits in an output register, so the next request is accepted while
// an earlier result waits; a stalled receiver holds rsp_data steady and stops
// further results from being produced.
// Reset clears all slots, cursors, the free counter and the tier select; no
// clearing pass is needed.
module tiered_extent_block_mapper import tebm_pkg::*; #(
   parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_data_type         req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_data_type         rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BLK_W-1:0]     csr_wdata
);

   chain_pkt_type        chain_pkt [MAX_SLOTS+1];
   logic [MAX_SLOTS-1:0] slot_wr_en;
   slot_wr_type          slot_wr;

   tebm_ctrl #(.MAX_SLOTS(MAX_SLOTS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .head_pkt   (chain_pkt[0]),
      .tail_pkt   (chain_pkt[MAX_SLOTS]),
      .slot_wr_en (slot_wr_en),
      .slot_wr    (slot_wr)
   );

   for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_slot
      tebm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .pkt_i   (chain_pkt[i]),
         .pkt_o   (chain_pkt[i+1]),
         .wr_en   (slot_wr_en[i]),
         .wr_data (slot_wr)
      );
   end

endmodule

// ----- rtl/core/tebm_checker.sv -----
// Port-level checks for the tiered extent block mapper, bound to the top level.
module tebm_checker import tebm_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input rsp_data_type         rsp_data
);

   // a held result must stay put until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // one transaction in flight: ready drops after an acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction accepted during a lookup");

   // hole and no-space results carry block zero
   a_no_map_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STAT_HOLE || rsp_data.status == STAT_NOSPACE)
      |-> rsp_data.physical_block == '0)
      else $error("unmapped result with nonzero block");

   // a new allocation never hands out block zero
   a_new_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STAT_NEW |-> rsp_data.physical_block != '0)
      else $error("block zero reported as newly allocated");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind tiered_extent_block_mapper tebm_checker u_tebm_checker (.*);
